### sv/spq_pkg.sv
`default_nettype none

package spq_pkg;

  // Width of the fixed-size word fields.
  localparam int unsigned VALUE_BITS    = 32;
  localparam int unsigned PRIORITY_BITS = 16;
  localparam int unsigned COUNT_BITS    = 5;

  typedef enum logic [1:0] {
    ACT_ENQUEUE = 2'd0,
    ACT_DEQUEUE = 2'd1,
    ACT_REPORT  = 2'd2
  } spq_action_t;

  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_FULL     = 2'd1,
    ST_EMPTY    = 2'd2
  } spq_status_t;

  typedef struct packed {
    logic [1:0]               action;
    logic [VALUE_BITS-1:0]    item_value;
    logic [PRIORITY_BITS-1:0] item_priority;
  } spq_in_t;

  typedef struct packed {
    logic                     head_valid;
    logic [VALUE_BITS-1:0]    head_value;
    logic [PRIORITY_BITS-1:0] head_priority;
    logic [COUNT_BITS-1:0]    entry_count;
    logic [1:0]               status;
  } spq_out_t;

  // Per-cycle command broadcast to every cell of the chain.
  typedef struct packed {
    logic enq;
    logic deq;
  } spq_ctl_t;

endpackage

`default_nettype wire

### sv/sorted_priority_queue_core.sv
// Sorted priority queue built as a chain of compare-and-shift cells.
// Input channel (in_valid/in_ready/in_word) carries one command word: enqueue
// a value with a priority, dequeue the head, or just report the head.
// Output channel (out_valid/out_ready/out_word) returns one word per command
// with the head entry, a head-valid flag, the entry count and a status code.
// Every cell compares its stored priority with the incoming one in parallel
// and either holds, loads the new entry, or takes its left neighbor's entry;
// a dequeue moves every entry one cell toward the head. Equal priorities
// therefore leave in arrival order.
// The result word is valid the cycle after the command is accepted, and the
// queue takes one command per cycle while the output is not stalled; the
// cell registers double as the output register.
// While a result word is stalled by out_ready low, in_ready is low and the
// queue holds. A full queue drops an enqueue and reports it; a dequeue on an
// empty queue changes nothing and reports it.
// Reset (rst_n low, synchronous) empties the queue and the output register.
`default_nettype none

module sorted_priority_queue_core #(
  parameter int DEPTH          = 16,
  parameter int VALUE_WIDTH    = 32,
  parameter int PRIORITY_WIDTH = 16
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire spq_pkg::spq_in_t  in_word,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output spq_pkg::spq_out_t      out_word
);
  import spq_pkg::*;

  // Stored widths never exceed the word fields, which carry at most 32/16 bits.
  localparam int VW = (VALUE_WIDTH < int'(VALUE_BITS)) ? VALUE_WIDTH : int'(VALUE_BITS);
  localparam int PW = (PRIORITY_WIDTH < int'(PRIORITY_BITS)) ?
                      PRIORITY_WIDTH : int'(PRIORITY_BITS);
  localparam int CW = $clog2(DEPTH + 1);

  logic              in_fire;
  logic              out_valid_r;
  logic [CW-1:0]     count_r, count_nxt;
  logic [1:0]        status_r, status_nxt;
  spq_ctl_t          ctl;

  logic [VW-1:0]     new_value;
  logic [PW-1:0]     new_prio;

  logic [DEPTH-1:0]  cell_keep;
  logic [DEPTH-1:0]  cell_used;
  logic [VW-1:0]     cell_value [DEPTH];
  logic [PW-1:0]     cell_prio  [DEPTH];

  // The queue state only advances when the previous word has been taken or is
  // being taken in this cycle, so the cells can drive the result word directly.
  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;

  assign new_value = in_word.item_value[VW-1:0];
  assign new_prio  = in_word.item_priority[PW-1:0];

  // Decode the command into a broadcast shift request for the chain and the next count and status.
  always_comb begin
    ctl        = '0;
    count_nxt  = count_r;
    status_nxt = ST_DONE;
    if (in_fire) begin
      unique case (in_word.action)
        ACT_ENQUEUE: begin
          if (count_r == CW'(DEPTH)) begin
            status_nxt = ST_FULL;
          end else begin
            ctl.enq   = 1'b1;
            count_nxt = count_r + 1'b1;
          end
        end
        ACT_DEQUEUE: begin
          if (count_r == '0) begin
            status_nxt = ST_EMPTY;
          end else begin
            ctl.deq   = 1'b1;
            count_nxt = count_r - 1'b1;
          end
        end
        default: begin
          status_nxt = ST_DONE;
        end
      endcase
    end else begin
      status_nxt = status_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      count_r     <= '0;
      status_r    <= ST_DONE;
    end else begin
      count_r  <= count_nxt;
      status_r <= status_nxt;
      if (in_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // The chain: cell 0 is the head. Each cell sees its left neighbor's keep
  // decision and entry (for insertion) and its right neighbor's entry (for
  // removal). Beyond the tail the chain feeds in an empty entry.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic          l_keep;
    logic          l_used;
    logic [VW-1:0] l_value;
    logic [PW-1:0] l_prio;
    logic          r_used;
    logic [VW-1:0] r_value;
    logic [PW-1:0] r_prio;

    if (i == 0) begin : g_head
      assign l_keep  = 1'b1;
      assign l_used  = 1'b0;
      assign l_value = '0;
      assign l_prio  = '0;
    end else begin : g_mid
      assign l_keep  = cell_keep[i-1];
      assign l_used  = cell_used[i-1];
      assign l_value = cell_value[i-1];
      assign l_prio  = cell_prio[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign r_used  = 1'b0;
      assign r_value = '0;
      assign r_prio  = '0;
    end else begin : g_body
      assign r_used  = cell_used[i+1];
      assign r_value = cell_value[i+1];
      assign r_prio  = cell_prio[i+1];
    end

    spq_cell #(
      .VW (VW),
      .PW (PW)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctl         (ctl),
      .new_value   (new_value),
      .new_prio    (new_prio),
      .left_keep   (l_keep),
      .left_used   (l_used),
      .left_value  (l_value),
      .left_prio   (l_prio),
      .right_used  (r_used),
      .right_value (r_value),
      .right_prio  (r_prio),
      .keep        (cell_keep[i]),
      .used        (cell_used[i]),
      .value       (cell_value[i]),
      .prio        (cell_prio[i])
    );
  end

  // Result word straight from the head cell; an empty head reads as zero.
  always_comb begin
    out_word               = '0;
    out_word.head_valid    = cell_used[0];
    out_word.entry_count   = COUNT_BITS'(count_r);
    out_word.status        = status_r;
    if (cell_used[0]) begin
      out_word.head_value    = VALUE_BITS'(cell_value[0]);
      out_word.head_priority = PRIORITY_BITS'(cell_prio[0]);
    end
  end

  // The head flag follows the count.
  a_head_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
    cell_used[0] == (count_r != '0))
    else $error("head valid disagrees with entry count");

  // Occupied cells form a contiguous run from the head, as long as the count.
  a_used_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    (((cell_used + 1'b1) & cell_used) == '0) && ($countones(cell_used) == count_r))
    else $error("occupied cells are not a contiguous run of count entries");

  // A dequeue on an empty queue is reported and leaves the count at zero.
  a_empty_dequeue: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (in_word.action == ACT_DEQUEUE) && (count_r == '0)) |=>
      ((status_r == ST_EMPTY) && (count_r == '0)))
    else $error("dequeue on empty queue not reported");

  // The chain holds while a result word is stalled.
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> $stable(count_r) && $stable(cell_used))
    else $error("queue changed while result word was stalled");

endmodule

`default_nettype wire

### sv/spq_cell.sv
`default_nettype none

module spq_cell #(
  parameter int VW = 32,
  parameter int PW = 16
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire spq_pkg::spq_ctl_t ctl,
  input  wire logic [VW-1:0]    new_value,
  input  wire logic [PW-1:0]    new_prio,
  input  wire logic             left_keep,
  input  wire logic             left_used,
  input  wire logic [VW-1:0]    left_value,
  input  wire logic [PW-1:0]    left_prio,
  input  wire logic             right_used,
  input  wire logic [VW-1:0]    right_value,
  input  wire logic [PW-1:0]    right_prio,
  output logic                  keep,
  output logic                  used,
  output logic [VW-1:0]         value,
  output logic [PW-1:0]         prio
);
  import spq_pkg::*;

  logic          used_r, used_nxt;
  logic [VW-1:0] value_r, value_nxt;
  logic [PW-1:0] prio_r, prio_nxt;

  // A cell keeps its entry when the entry is ahead of the new one.
  assign keep = used_r && (prio_r <= new_prio);

  always_comb begin
    used_nxt  = used_r;
    value_nxt = value_r;
    prio_nxt  = prio_r;
    if (ctl.enq) begin
      if (!keep) begin
        if (left_keep) begin
          used_nxt  = 1'b1;
          value_nxt = new_value;
          prio_nxt  = new_prio;
        end else begin
          used_nxt  = left_used;
          value_nxt = left_value;
          prio_nxt  = left_prio;
        end
      end
    end else if (ctl.deq) begin
      used_nxt  = right_used;
      value_nxt = right_value;
      prio_nxt  = right_prio;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= 1'b0;
    end else begin
      used_r <= used_nxt;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
    prio_r  <= prio_nxt;
  end

  assign used  = used_r;
  assign value = value_r;
  assign prio  = prio_r;

endmodule

`default_nettype wire
